FILE: rtl/ptau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptau_pkg: shared definitions for the periodic task activation unit
// Operation and status codes, field widths and registration limits.
// ----------------------------------------------------------------------------
package ptau_pkg;

  localparam int NUM_TASKS_DEF = 8;

  localparam int FUNC_W   = 2;
  localparam int ID_W     = 3;
  localparam int TIME_W   = 32;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 2;
  localparam int MASK_W   = 8;
  localparam int PERIOD_W = 30;

  localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REGISTER = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ACTIVATE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FINISHED = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_LOST   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ID = 2'd3;

  localparam logic [TIME_W-1:0] TIME_RANGE_MASK = 32'hc000_0000;
  localparam logic [PRIO_W-1:0] MAX_PRIO        = 8'd15;

endpackage

FILE: rtl/periodic_task_activation_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_activation_unit_top: cyclic task activation table
// Task table in small memories, walked one entry per cycle by a sequencer
// that shares one due-time compare/advance datapath.
// ----------------------------------------------------------------------------
// Sequence: register and bad-id ops go from accept through S_FIN to the
//   output register; activate/finished pass S_ACT first; tick walks S_WALK over every task (S_FIN with no tasks).
// Throughput: one operation at a time; the next is taken once the result has
//   moved to the output register. The tick walk (one table entry per cycle
//   through the registered table read port) sets the worst case.
// Reset (rst, synchronous): os_time, task count, pending bits cleared.
module periodic_task_activation_unit_top #(
  parameter int NUM_TASKS = ptau_pkg::NUM_TASKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ptau_pkg::FUNC_W-1:0]     func,
  input  logic [ptau_pkg::ID_W-1:0]       task_id,
  input  logic [ptau_pkg::TIME_W-1:0]     cycle_ms,
  input  logic [ptau_pkg::TIME_W-1:0]     first_ms,
  input  logic [ptau_pkg::PRIO_W-1:0]     prio,
  input  logic                            has_handler,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ptau_pkg::STATUS_W-1:0]   status,
  output logic [ptau_pkg::ID_W-1:0]       assigned_id,
  output logic [ptau_pkg::MASK_W-1:0]     ready_mask,
  output logic [ptau_pkg::MASK_W-1:0]     overrun_mask,
  output logic [ptau_pkg::MASK_W-1:0]     pending_mask,
  output logic [ptau_pkg::TIME_W-1:0]     loss_total
);

  localparam int IDX_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W  = $clog2(NUM_TASKS + 1);
  localparam int TW     = ptau_pkg::TIME_W;
  localparam int MW     = ptau_pkg::MASK_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_ACT  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // task table
  logic [TW-1:0]                 due_mem    [NUM_TASKS];
  logic [ptau_pkg::PERIOD_W-1:0] period_mem [NUM_TASKS];
  logic [TW-1:0]                 loss_mem   [NUM_TASKS];

  logic [TW-1:0]                 rd_due;
  logic [ptau_pkg::PERIOD_W-1:0] rd_period;
  logic [TW-1:0]                 rd_loss;
  logic [IDX_W-1:0]              rd_addr;
  logic                          mem_we;
  logic [IDX_W-1:0]              wr_addr;
  logic [TW-1:0]                 wr_due;
  logic [ptau_pkg::PERIOD_W-1:0] wr_period;
  logic [TW-1:0]                 wr_loss;

  // control state
  logic [1:0]                  state, state_next;
  logic [IDX_W-1:0]            idx, idx_next;
  logic [ptau_pkg::FUNC_W-1:0] op_func, op_func_next;
  logic [IDX_W-1:0]            op_id, op_id_next;
  logic [TW-1:0]               os_time, os_time_next;
  logic [CNT_W-1:0]            task_count, task_count_next;
  logic [NUM_TASKS-1:0]        pending, pending_next;
  logic                        out_valid_next;
  logic                        out_load;

  // result under construction
  logic [ptau_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [ptau_pkg::ID_W-1:0]     res_assigned, res_assigned_next;
  logic [NUM_TASKS-1:0]          res_ready, res_ready_next;
  logic [NUM_TASKS-1:0]          res_overrun, res_overrun_next;
  logic [TW-1:0]                 res_loss, res_loss_next;

  // datapath
  logic [TW-1:0]          due_diff;
  logic                   is_due;
  logic [TW-1:0]          loss_inc;
  logic [IDX_W+2:0]       id_ext;
  logic [IDX_W-1:0]       id_idx;
  logic                   id_ok;
  logic [IDX_W+2:0]       cnt_ext;
  logic [IDX_W-1:0]       cnt_idx;
  logic                   walk_last;
  logic                   reg_bad;
  logic [MW+NUM_TASKS-1:0] ready_ext, overrun_ext, pending_ext;

  assign in_ready = (state == S_IDLE);

  assign due_diff = rd_due - os_time;
  assign is_due   = (rd_period != '0) && (due_diff[TW-1] || (due_diff == '0));
  assign loss_inc = (rd_loss == {TW{1'b1}}) ? rd_loss : rd_loss + 1'b1;

  assign id_ext  = {IDX_W'(0), task_id};
  assign id_idx  = id_ext[IDX_W-1:0];
  assign id_ok   = (32'(task_id) < 32'(task_count));
  assign cnt_idx = task_count[IDX_W-1:0];
  assign cnt_ext = {3'b000, cnt_idx};
  assign walk_last = ((CNT_W'(idx) + CNT_W'(1)) == task_count);

  always_comb begin
    reg_bad = 1'b0;
    if (task_count == CNT_W'(NUM_TASKS)) begin
      reg_bad = 1'b1;
    end else if (!has_handler) begin
      reg_bad = 1'b1;
    end else if ((prio == '0) || (prio > ptau_pkg::MAX_PRIO)) begin
      reg_bad = 1'b1;
    end else if (cycle_ms == '0) begin
      reg_bad = (first_ms != '0);
    end else begin
      reg_bad = (((cycle_ms | first_ms) & ptau_pkg::TIME_RANGE_MASK) != '0);
    end
  end

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    op_func_next      = op_func;
    op_id_next        = op_id;
    os_time_next      = os_time;
    task_count_next   = task_count;
    pending_next      = pending;
    res_status_next   = res_status;
    res_assigned_next = res_assigned;
    res_ready_next    = res_ready;
    res_overrun_next  = res_overrun;
    res_loss_next     = res_loss;
    out_valid_next    = out_valid && !out_ready;
    out_load          = 1'b0;
    rd_addr           = idx;
    mem_we            = 1'b0;
    wr_addr           = idx;
    wr_due            = rd_due;
    wr_period         = rd_period;
    wr_loss           = rd_loss;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_func_next      = func;
          op_id_next        = id_idx;
          res_status_next   = ptau_pkg::STATUS_OK;
          res_assigned_next = '0;
          res_ready_next    = '0;
          res_overrun_next  = '0;
          res_loss_next     = '0;
          case (func)
            ptau_pkg::FUNC_TICK: begin
              if (task_count == '0) begin
                os_time_next = os_time + 1'b1;
                state_next   = S_FIN;
              end else begin
                idx_next   = '0;
                rd_addr    = '0;
                state_next = S_WALK;
              end
            end
            ptau_pkg::FUNC_REGISTER: begin
              if (reg_bad) begin
                res_status_next = ptau_pkg::STATUS_REJECT;
              end else begin
                mem_we                = 1'b1;
                wr_addr               = cnt_idx;
                wr_due                = first_ms;
                wr_period             = cycle_ms[ptau_pkg::PERIOD_W-1:0];
                wr_loss               = '0;
                pending_next[cnt_idx] = 1'b0;
                res_assigned_next     = cnt_ext[2:0];
                task_count_next       = task_count + 1'b1;
              end
              state_next = S_FIN;
            end
            default: begin
              if (!id_ok) begin
                res_status_next = ptau_pkg::STATUS_BAD_ID;
                state_next      = S_FIN;
              end else begin
                rd_addr    = id_idx;
                state_next = S_ACT;
              end
            end
          endcase
        end
      end

      S_WALK: begin
        if (is_due) begin
          mem_we = 1'b1;
          wr_due = rd_due + {2'b00, rd_period};
          if (pending[idx]) begin
            wr_loss               = loss_inc;
            res_overrun_next[idx] = 1'b1;
          end else begin
            pending_next[idx]   = 1'b1;
            res_ready_next[idx] = 1'b1;
          end
        end
        if (walk_last) begin
          os_time_next = os_time + 1'b1;
          state_next   = S_FIN;
        end else begin
          // fetch the next entry while this one is written back
          idx_next = idx + 1'b1;
          rd_addr  = idx + 1'b1;
        end
      end

      S_ACT: begin
        wr_addr = op_id;
        if (op_func == ptau_pkg::FUNC_ACTIVATE) begin
          if (pending[op_id]) begin
            mem_we                  = 1'b1;
            wr_loss                 = loss_inc;
            res_overrun_next[op_id] = 1'b1;
            res_status_next         = ptau_pkg::STATUS_LOST;
            res_loss_next           = loss_inc;
          end else begin
            pending_next[op_id]   = 1'b1;
            res_ready_next[op_id] = 1'b1;
            res_loss_next         = rd_loss;
          end
        end else begin
          pending_next[op_id] = 1'b0;
          res_loss_next       = rd_loss;
        end
        state_next = S_FIN;
      end

      S_FIN: begin
        if (!out_valid || out_ready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign ready_ext   = {{MW{1'b0}}, res_ready};
  assign overrun_ext = {{MW{1'b0}}, res_overrun};
  assign pending_ext = {{MW{1'b0}}, pending};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      due_mem[wr_addr]    <= wr_due;
      period_mem[wr_addr] <= wr_period;
      loss_mem[wr_addr]   <= wr_loss;
    end
    rd_due    <= due_mem[rd_addr];
    rd_period <= period_mem[rd_addr];
    rd_loss   <= loss_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      os_time    <= '0;
      task_count <= '0;
      pending    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      os_time    <= os_time_next;
      task_count <= task_count_next;
      pending    <= pending_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx          <= idx_next;
    op_func      <= op_func_next;
    op_id        <= op_id_next;
    res_status   <= res_status_next;
    res_assigned <= res_assigned_next;
    res_ready    <= res_ready_next;
    res_overrun  <= res_overrun_next;
    res_loss     <= res_loss_next;
    if (out_load) begin
      status       <= res_status;
      assigned_id  <= res_assigned;
      ready_mask   <= ready_ext[MW-1:0];
      overrun_mask <= overrun_ext[MW-1:0];
      pending_mask <= pending_ext[MW-1:0];
      loss_total   <= res_loss;
    end
  end

endmodule

FILE: rtl/ptau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptau_checker: port-level checks for the periodic task activation unit
// Watches both channels and the status, ready/overrun mask and loss fields; bound to the top level.
// ----------------------------------------------------------------------------
module ptau_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ptau_pkg::STATUS_W-1:0] status,
  input logic [ptau_pkg::MASK_W-1:0]   ready_mask,
  input logic [ptau_pkg::MASK_W-1:0]   overrun_mask,
  input logic [ptau_pkg::TIME_W-1:0]   loss_total
);

  // a held result beat keeps its status and loss total
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(loss_total))
    else $error("result beat changed while stalled");

  // the unit is busy in the cycle after taking an operation
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  // a task is either made pending or loses its activation, never both
  a_ready_overrun_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ready_mask & overrun_mask) == '0)
    else $error("task both readied and overrun");

  a_lost_one_task: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ptau_pkg::STATUS_LOST |->
      $onehot(overrun_mask) && ready_mask == '0 && loss_total != '0)
    else $error("lost activation without a single overrun task");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ptau_pkg::STATUS_REJECT || status == ptau_pkg::STATUS_BAD_ID) |->
      ready_mask == '0 && overrun_mask == '0 && loss_total == '0)
    else $error("rejected operation reports activity");

endmodule

bind periodic_task_activation_unit_top ptau_checker u_ptau_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .ready_mask   (ready_mask),
  .overrun_mask (overrun_mask),
  .loss_total   (loss_total)
);
